@@ rtl/bni_pkg.sv @@
`timescale 1ns / 1ps

package bni_pkg;

    // Field widths
    localparam int MODE_W     = 1;
    localparam int CHAN_W     = 10;
    localparam int VALUE_W    = 16;
    localparam int VAR_W      = 32;
    localparam int SCALE_W    = 24;
    localparam int CCOUNT_W   = 11;
    localparam int INNER_W    = 16;
    localparam int EPS_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Inverse square root unit: 2^48 / s by restoring division, then a bitwise root
    localparam int SUM_W      = VAR_W + 1;
    localparam int QUOT_W     = 49;
    localparam int DIV_STEPS  = 49;
    localparam int ROOT_STEPS = 25;
    localparam int STEP_W     = 6;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFFFFFF;

    // Product and rounding
    localparam int PROD_W = (VALUE_W + 1) + SCALE_W;
    localparam int FRAC_DROP = 16;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(32'h8000);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_STATS  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_INNER_SIZE    = 2'd1,
        CFG_EPSILON       = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROOT,
        ST_STORE
    } t_stat_state;

endpackage

@@ rtl/bni_in_if.sv @@
`timescale 1ns / 1ps

interface bni_in_if;
    logic                              valid;
    logic                              ready;
    logic [bni_pkg::MODE_W-1:0]        mode;
    logic [bni_pkg::CHAN_W-1:0]        stat_channel;
    logic signed [bni_pkg::VALUE_W-1:0] value;
    logic [bni_pkg::VAR_W-1:0]         variance;

    modport source (output valid, output mode, output stat_channel, output value,
                    output variance, input ready);
    modport sink   (input valid, input mode, input stat_channel, input value,
                    input variance, output ready);
endinterface

@@ rtl/bni_out_if.sv @@
`timescale 1ns / 1ps

interface bni_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bni_pkg::VALUE_W-1:0] normalized;
    logic [bni_pkg::CHAN_W-1:0]         channel;
    logic                               block_end;

    modport source (output valid, output normalized, output channel, output block_end,
                    input ready);
    modport sink   (input valid, input normalized, input channel, input block_end,
                    output ready);
endinterface

@@ rtl/batch_norm_inference.sv @@
`timescale 1ns / 1ps
// Sample items: table read into the stage 1 registers, multiply into stage 2, round into
// the output register; one sample per cycle while the result side keeps taking
// transfers. The whole pipeline stalls on a held result.
// Statistics load: input held off through 49 division steps, 25 root steps and one write
// to the channel table; only the table write when variance plus epsilon is zero.
// Reset: registers back to channel_count 1, inner_size 1, epsilon 1, positions 0,
// pipeline empty. Channel tables are not cleared and hold garbage until loaded.
module batch_norm_inference #(
    parameter int MAX_CHANNELS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bni_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bni_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    bni_in_if.sink                              i_in,
    bni_out_if.source                           o_out
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ENTRY_W = bni_pkg::SCALE_W + bni_pkg::VALUE_W;

    // Configuration registers
    logic [bni_pkg::CCOUNT_W-1:0] r_channel_count;
    logic [bni_pkg::INNER_W-1:0]  r_inner_size;
    logic [bni_pkg::EPS_W-1:0]    r_epsilon;

    // Position counters
    logic [bni_pkg::CCOUNT_W-1:0] r_chan_pos, n_chan_pos;
    logic [bni_pkg::INNER_W-1:0]  r_inner_pos, n_inner_pos;

    // Channel table: {scale, mean}
    logic [ENTRY_W-1:0] mem_table [MAX_CHANNELS];
    logic [ENTRY_W-1:0] r_rd_entry;

    // Statistics unit
    bni_pkg::t_stat_state r_state, n_state;
    logic [bni_pkg::STEP_W-1:0]  r_step, n_step;
    logic [bni_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [bni_pkg::SUM_W-1:0]   r_rem, n_rem;
    logic [bni_pkg::QUOT_W-1:0]  r_q, n_q;
    logic [bni_pkg::QUOT_W-1:0]  r_res, n_res;
    logic [bni_pkg::QUOT_W-1:0]  r_bit, n_bit;
    logic [AW-1:0]               r_stat_addr, n_stat_addr;
    logic signed [bni_pkg::VALUE_W-1:0] r_stat_mean, n_stat_mean;

    // Sample pipeline
    logic                               r_s1_valid;
    logic signed [bni_pkg::VALUE_W-1:0] r_s1_value;
    logic [bni_pkg::CHAN_W-1:0]         r_s1_ch;
    logic                               r_s1_end;
    logic                               r_s2_valid;
    logic [bni_pkg::PROD_W-1:0]         r_s2_prod;
    logic                               r_s2_neg;
    logic [bni_pkg::CHAN_W-1:0]         r_s2_ch;
    logic                               r_s2_end;
    logic                               r_out_valid;
    logic signed [bni_pkg::VALUE_W-1:0] r_out_norm;
    logic [bni_pkg::CHAN_W-1:0]         r_out_ch;
    logic                               r_out_end;

    logic                               adv;
    logic                               acc;
    logic                               acc_sample;
    logic                               acc_stats;
    logic [bni_pkg::CCOUNT_W-1:0]       cc_eff;
    logic [bni_pkg::INNER_W-1:0]        is_eff;
    logic [bni_pkg::CCOUNT_W-1:0]       cur_ch;
    logic                               last_inner;
    logic                               last_chan;
    logic [AW-1:0]                      rd_addr;
    logic [bni_pkg::SUM_W-1:0]          in_sum;
    logic [bni_pkg::SUM_W:0]            div_trial;
    logic                               div_ge;
    logic                               div_bit;
    logic [bni_pkg::QUOT_W:0]           root_trial;
    logic                               root_take;
    logic [bni_pkg::SCALE_W-1:0]        store_scale;
    logic signed [bni_pkg::VALUE_W:0]   diff;
    logic [bni_pkg::VALUE_W:0]          diff_mag;
    logic [bni_pkg::SCALE_W-1:0]        rd_scale;
    logic signed [bni_pkg::VALUE_W-1:0] rd_mean;
    logic [bni_pkg::PROD_W:0]           round_sum;
    logic [bni_pkg::PROD_W-bni_pkg::FRAC_DROP:0] rounded;
    logic signed [bni_pkg::VALUE_W-1:0] sat_val;

    // Handshake: whole sample pipeline advances when the output register frees up
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == bni_pkg::ST_IDLE) && adv;
    assign acc        = i_in.valid && i_in.ready;
    assign acc_sample = acc && (i_in.mode == bni_pkg::MODE_SAMPLE);
    assign acc_stats  = acc && (i_in.mode == bni_pkg::MODE_STATS);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= bni_pkg::CCOUNT_W'(1);
            r_inner_size    <= bni_pkg::INNER_W'(1);
            r_epsilon       <= bni_pkg::EPS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bni_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[bni_pkg::CCOUNT_W-1:0];
                bni_pkg::CFG_INNER_SIZE:    r_inner_size    <= i_cfg_data[bni_pkg::INNER_W-1:0];
                bni_pkg::CFG_EPSILON:       r_epsilon       <= i_cfg_data[bni_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts and current channel
    always_comb begin
        if (r_channel_count == '0) begin
            cc_eff = bni_pkg::CCOUNT_W'(1);
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            cc_eff = bni_pkg::CCOUNT_W'(MAX_CHANNELS);
        end else begin
            cc_eff = r_channel_count;
        end
        is_eff     = (r_inner_size == '0) ? bni_pkg::INNER_W'(1) : r_inner_size;
        cur_ch     = (r_chan_pos >= cc_eff) ? cc_eff - 1'b1 : r_chan_pos;
        last_inner = ({1'b0, r_inner_pos} + 1'b1) >= {1'b0, is_eff};
        last_chan  = ({1'b0, cur_ch} + 1'b1) >= {1'b0, cc_eff};
        rd_addr    = AW'(cur_ch);
        n_inner_pos = r_inner_pos;
        n_chan_pos  = r_chan_pos;
        if (acc_sample) begin
            if (last_inner) begin
                n_inner_pos = '0;
                n_chan_pos  = last_chan ? '0 : cur_ch + 1'b1;
            end else begin
                n_inner_pos = r_inner_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_pos  <= '0;
            r_inner_pos <= '0;
        end else begin
            r_chan_pos  <= n_chan_pos;
            r_inner_pos <= n_inner_pos;
        end
    end

    // Table: written by the statistics unit, read for each sample transfer
    always_ff @(posedge i_clk) begin
        if (r_state == bni_pkg::ST_STORE) begin
            mem_table[r_stat_addr] <= {store_scale, r_stat_mean};
        end
        if (adv) begin
            r_rd_entry <= mem_table[rd_addr];
        end
    end

    // Statistics unit: 2^48 / (var + eps) one quotient bit a cycle, then root
    assign in_sum     = {1'b0, i_in.variance} + bni_pkg::SUM_W'(r_epsilon);
    assign div_bit    = (r_step == '0);
    assign div_trial  = {r_rem, div_bit};
    assign div_ge     = div_trial >= {1'b0, r_sum};
    assign root_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign root_take  = {1'b0, r_q} >= root_trial;
    assign store_scale = (r_res > bni_pkg::QUOT_W'(bni_pkg::SCALE_MAX)) ?
                         bni_pkg::SCALE_MAX : r_res[bni_pkg::SCALE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_q         = r_q;
        n_res       = r_res;
        n_bit       = r_bit;
        n_stat_addr = r_stat_addr;
        n_stat_mean = r_stat_mean;
        case (r_state)
            bni_pkg::ST_IDLE: begin
                if (acc_stats && (32'(i_in.stat_channel) < MAX_CHANNELS)) begin
                    n_stat_addr = AW'(i_in.stat_channel);
                    n_stat_mean = i_in.value;
                    n_sum       = in_sum;
                    n_rem       = '0;
                    n_q         = '0;
                    n_step      = '0;
                    if (in_sum == '0) begin
                        n_res   = bni_pkg::QUOT_W'(bni_pkg::SCALE_MAX);
                        n_state = bni_pkg::ST_STORE;
                    end else begin
                        n_state = bni_pkg::ST_DIV;
                    end
                end
            end
            bni_pkg::ST_DIV: begin
                n_rem  = div_ge ? bni_pkg::SUM_W'(div_trial - {1'b0, r_sum})
                                : div_trial[bni_pkg::SUM_W-1:0];
                n_q    = {r_q[bni_pkg::QUOT_W-2:0], div_ge};
                n_step = r_step + 1'b1;
                if (r_step == bni_pkg::STEP_W'(bni_pkg::DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_res   = '0;
                    n_bit   = {1'b1, {(bni_pkg::QUOT_W-1){1'b0}}};
                    n_state = bni_pkg::ST_ROOT;
                end
            end
            bni_pkg::ST_ROOT: begin
                if (root_take) begin
                    n_q   = bni_pkg::QUOT_W'({1'b0, r_q} - root_trial);
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit  = r_bit >> 2;
                n_step = r_step + 1'b1;
                if (r_step == bni_pkg::STEP_W'(bni_pkg::ROOT_STEPS - 1)) begin
                    n_state = bni_pkg::ST_STORE;
                end
            end
            bni_pkg::ST_STORE: begin
                n_state = bni_pkg::ST_IDLE;
            end
            default: begin
                n_state = bni_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bni_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_res       <= n_res;
        r_bit       <= n_bit;
        r_stat_addr <= n_stat_addr;
        r_stat_mean <= n_stat_mean;
    end

    // Stage 2 operands: difference magnitude against the table scale
    assign rd_scale = r_rd_entry[ENTRY_W-1:bni_pkg::VALUE_W];
    assign rd_mean  = r_rd_entry[bni_pkg::VALUE_W-1:0];
    assign diff     = (bni_pkg::VALUE_W+1)'(r_s1_value) - (bni_pkg::VALUE_W+1)'(rd_mean);
    assign diff_mag = diff[bni_pkg::VALUE_W] ? (bni_pkg::VALUE_W+1)'(-diff)
                                             : (bni_pkg::VALUE_W+1)'(diff);

    // Stage 3: round half away from zero, then saturate
    assign round_sum = {1'b0, r_s2_prod} + bni_pkg::ROUND_HALF;
    assign rounded   = round_sum[bni_pkg::PROD_W:bni_pkg::FRAC_DROP];
    always_comb begin
        if (r_s2_neg) begin
            if (rounded > (bni_pkg::PROD_W-bni_pkg::FRAC_DROP+1)'(32768)) begin
                sat_val = -16'sd32768;
            end else begin
                sat_val = bni_pkg::VALUE_W'(-rounded[bni_pkg::VALUE_W:0]);
            end
        end else begin
            if (rounded > (bni_pkg::PROD_W-bni_pkg::FRAC_DROP+1)'(32767)) begin
                sat_val = 16'sd32767;
            end else begin
                sat_val = rounded[bni_pkg::VALUE_W-1:0];
            end
        end
    end

    // Advance the sample pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= acc_sample;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Advance the sample pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_value <= i_in.value;
            r_s1_ch    <= cur_ch[bni_pkg::CHAN_W-1:0];
            r_s1_end   <= last_inner && last_chan;
            r_s2_prod  <= diff_mag * rd_scale;
            r_s2_neg   <= diff[bni_pkg::VALUE_W];
            r_s2_ch    <= r_s1_ch;
            r_s2_end   <= r_s1_end;
            r_out_norm <= sat_val;
            r_out_ch   <= r_s2_ch;
            r_out_end  <= r_s2_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.normalized = r_out_norm;
    assign o_out.channel    = r_out_ch;
    assign o_out.block_end  = r_out_end;

    // A valid statistics load starts the unit
    a_stats_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_stats && (32'(i_in.stat_channel) < MAX_CHANNELS)) |=>
            (r_state != bni_pkg::ST_IDLE))
        else $error("statistics load did not start the unit");

    // The table write lasts exactly one cycle
    a_store_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bni_pkg::ST_STORE) |=> (r_state == bni_pkg::ST_IDLE))
        else $error("table write did not return to idle");

    // Step counter stays within the iteration lengths
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bni_pkg::ST_DIV) |-> (r_step < bni_pkg::STEP_W'(bni_pkg::DIV_STEPS))) and
        ((r_state == bni_pkg::ST_ROOT) |-> (r_step < bni_pkg::STEP_W'(bni_pkg::ROOT_STEPS))))
        else $error("iteration step out of range");

    // Inner position wraps after the last sample of a run
    a_inner_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_sample && last_inner) |=> (r_inner_pos == '0))
        else $error("inner position did not wrap");

endmodule
